// ----- rtl/mlp_pkg.sv -----
// Shared constants and types for the median edge detector pixel predictor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mlp_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int SAMPLE_W      = 8;
   localparam int RESID_W       = SAMPLE_W + 1;
   localparam int WIDTH_REG_W   = 13;
   localparam int COUNT_REG_W   = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_IDX_W     = 1;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = WIDTH_REG_W'(640);
   localparam logic [COUNT_REG_W-1:0] COUNT_RESET = COUNT_REG_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_WIDTH = 1'b0,
      REG_ROW_COUNT = 1'b1
   } csr_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [COL_W-1:0]    col_type;

endpackage

`default_nettype wire

// ----- rtl/mlp_line_ram.sv -----
// Line store: single-port synchronous RAM holding the previous image row.
// Read-before-write, one cycle read latency. Depends on mlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlp_line_ram (
   input  wire                 clock,
   input  wire                 en,
   input  mlp_pkg::col_type    addr,
   input  mlp_pkg::sample_type wr_data,
   output mlp_pkg::sample_type rd_data
);
   import mlp_pkg::*;

   sample_type mem_ff [MAX_WIDTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff   <= mem_ff[addr];
         mem_ff[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/med_pixel_predictor.sv -----
// Top level of the median edge detector pixel predictor.
// Depends on mlp_pkg and mlp_line_ram.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_sample
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_residual, rsp_prediction, rsp_plane_end
//   csr     | in        | csr_wen              | csr_index, csr_wdata
//
// One sample per clock unless stalled; a result passes stage 1, then the result register.
// The line store is read and written on the transfer edge at the same address,
// so consecutive samples never collide on an entry.
// Synchronous reset clears counters, neighbours and valids; the line store is not cleared.
// An output stall holds the result register; one more sample is taken into the middle stage.
`timescale 1ns / 1ps
`default_nettype none

module med_pixel_predictor (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [mlp_pkg::SAMPLE_W-1:0]         req_sample,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [mlp_pkg::RESID_W-1:0]   rsp_residual,
   output logic [mlp_pkg::SAMPLE_W-1:0]         rsp_prediction,
   output logic                                 rsp_plane_end,
   input  wire                                  csr_wen,
   input  wire  [mlp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [mlp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mlp_pkg::*;

   logic [WIDTH_REG_W-1:0] row_width_ff;
   logic [COUNT_REG_W-1:0] row_count_ff;
   col_type                col_ff, col_in;
   logic [COUNT_REG_W-1:0] row_ff, row_in;

   logic                   s1_valid_ff;
   sample_type             s1_sample_ff;
   logic                   s1_col_nz_ff;
   logic                   s1_row_nz_ff;
   logic                   s1_end_ff;
   sample_type             left_ff;
   sample_type             upper_left_ff;
   sample_type             above;

   logic                   rsp_valid_ff;
   logic [RESID_W-1:0]     rsp_residual_ff, rsp_residual_in;
   sample_type             rsp_prediction_ff, rsp_prediction_in;
   logic                   rsp_plane_end_ff;

   logic                   accept;
   logic                   out_free;
   logic                   s1_move;
   logic [WIDTH_REG_W-1:0] eff_width;
   logic [COUNT_REG_W-1:0] eff_count;
   logic                   last_col;
   logic                   last_row;

   sample_type             nb_a, nb_b, nb_c, lo, hi;
   logic [SAMPLE_W:0]      ab_sum;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_RESET;
         row_count_ff <= COUNT_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            REG_ROW_WIDTH: row_width_ff <= csr_wdata[WIDTH_REG_W-1:0];
            REG_ROW_COUNT: row_count_ff <= csr_wdata[COUNT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // position counters
   always_comb begin
      if (row_width_ff == '0) begin
         eff_width = WIDTH_REG_W'(1);
      end else if (row_width_ff > WIDTH_REG_W'(MAX_WIDTH)) begin
         eff_width = WIDTH_REG_W'(MAX_WIDTH);
      end else begin
         eff_width = row_width_ff;
      end
      eff_count = (row_count_ff == '0) ? COUNT_REG_W'(1) : row_count_ff;
      last_col  = (WIDTH_REG_W'(col_ff) + WIDTH_REG_W'(1)) >= eff_width;
      last_row  = ((COUNT_REG_W+1)'(row_ff) + (COUNT_REG_W+1)'(1))
                  >= (COUNT_REG_W+1)'(eff_count);
      col_in    = last_col ? '0 : col_ff + COL_W'(1);
      if (!last_col) begin
         row_in = row_ff;
      end else if (last_row) begin
         row_in = '0;
      end else begin
         row_in = row_ff + COUNT_REG_W'(1);
      end
   end

   mlp_line_ram u_line_ram (
      .clock   (clock),
      .en      (accept),
      .addr    (col_ff),
      .wr_data (req_sample),
      .rd_data (above)
   );

   // stage 1: line store data lands, neighbours held
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         if (accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            left_ff       <= s1_sample_ff;
            upper_left_ff <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample;
         s1_col_nz_ff <= (col_ff != '0);
         s1_row_nz_ff <= (row_ff != '0);
         s1_end_ff    <= last_col && last_row;
      end
   end

   // MED prediction
   always_comb begin
      nb_a   = s1_col_nz_ff ? left_ff : '0;
      nb_b   = s1_row_nz_ff ? above : '0;
      nb_c   = (s1_col_nz_ff && s1_row_nz_ff) ? upper_left_ff : '0;
      lo     = (nb_a < nb_b) ? nb_a : nb_b;
      hi     = (nb_a < nb_b) ? nb_b : nb_a;
      ab_sum = {1'b0, nb_a} + {1'b0, nb_b};
      if (nb_c <= lo) begin
         rsp_prediction_in = hi;
      end else if (nb_c >= hi) begin
         rsp_prediction_in = lo;
      end else begin
         rsp_prediction_in = SAMPLE_W'(ab_sum - {1'b0, nb_c});
      end
      rsp_residual_in = {1'b0, s1_sample_ff} - {1'b0, rsp_prediction_in};
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_residual_ff   <= rsp_residual_in;
         rsp_prediction_ff <= rsp_prediction_in;
         rsp_plane_end_ff  <= s1_end_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_residual   = $signed(rsp_residual_ff);
   assign rsp_prediction = rsp_prediction_ff;
   assign rsp_plane_end  = rsp_plane_end_ff;

endmodule

`default_nettype wire

// ----- rtl/mlp_checker.sv -----
// Port-level checks for med_pixel_predictor, attached by bind.
// Depends on mlp_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module mlp_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_stall,
   input wire [mlp_pkg::SAMPLE_W-1:0]         req_sample,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input wire signed [mlp_pkg::RESID_W-1:0]   rsp_residual,
   input wire [mlp_pkg::SAMPLE_W-1:0]         rsp_prediction,
   input wire                                 rsp_plane_end,
   input wire                                 csr_wen,
   input wire [mlp_pkg::CSR_IDX_W-1:0]        csr_index,
   input wire [mlp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mlp_pkg::*;

   logic [RESID_W:0] rebuilt;

   // prediction plus residual gives back the sample, so it must fit 8 bits
   assign rebuilt = {2'b00, rsp_prediction} + {rsp_residual[RESID_W-1], rsp_residual};

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_residual)
         && $stable(rsp_prediction) && $stable(rsp_plane_end)))
      else $error("result changed under stall");

   a_sample_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rebuilt[RESID_W:SAMPLE_W] == 2'b00))
      else $error("prediction plus residual out of sample range");

   a_empty_output_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |-> ##2 rsp_valid)
      else $error("transfer produced no result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   wire unused_ok = &{1'b0, req_sample, csr_wen, csr_index, csr_wdata};

endmodule

bind med_pixel_predictor mlp_checker u_mlp_checker (.*);

`default_nettype wire
